// ===== rtl/lse_pkg.sv =====
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants of the LIFO stack engine.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int DATA_W      = 32;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int S_USER_W    = ACTION_W;
    localparam int M_USER_W    = 1 + STATUS_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [ACTION_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_SWAP = 3'd2,
        OP_PEEK = 3'd3,
        OP_DUMP = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  value;
    } req_t;

endpackage

// ===== rtl/lse_front.sv =====
// ----------------------------------------------------------------------------
// lse_front
// Input side: takes requests, drops unknown actions, forwards the rest.
// ----------------------------------------------------------------------------
module lse_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lse_pkg::S_USER_W-1:0]  s_tuser,   // [2:0] action
    input  logic [lse_pkg::DATA_W-1:0]    s_tdata,   // [31:0] push_value
    input  logic                          q_full,
    output logic                          q_push,
    output lse_pkg::req_t                 q_req
);

    logic known;

    always_comb begin
        unique case (s_tuser) inside
            lse_pkg::OP_PUSH, lse_pkg::OP_POP, lse_pkg::OP_SWAP,
            lse_pkg::OP_PEEK, lse_pkg::OP_DUMP: known = 1'b1;
            default:                            known = 1'b0;
        endcase
    end

    assign s_tready    = !q_full;
    // unknown actions are consumed here and never reach the back end
    assign q_push      = s_tvalid && s_tready && known;
    assign q_req.op    = lse_pkg::op_t'(s_tuser);
    assign q_req.value = s_tdata;

endmodule

// ===== rtl/lse_queue.sv =====
// ----------------------------------------------------------------------------
// lse_queue
// Short request queue between the front and the executor.
// ----------------------------------------------------------------------------
module lse_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lse_pkg::req_t  push_req,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output lse_pkg::req_t  pop_req
);

    lse_pkg::req_t                  slot_reg [lse_pkg::QUEUE_DEPTH];
    logic [lse_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lse_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lse_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                           do_push, do_pop;

    assign full      = (cnt_reg == lse_pkg::QCNT_W'(lse_pkg::QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_req   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == lse_pkg::QPTR_W'(lse_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == lse_pkg::QPTR_W'(lse_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== rtl/lse_exec.sv =====
// ----------------------------------------------------------------------------
// lse_exec
// Back end: entry memory, entry count, action sequencer and output register.
// ----------------------------------------------------------------------------
module lse_exec (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  lse_pkg::req_t                 q_req,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lse_pkg::DATA_W-1:0]    m_tdata,   // [31:0] value
    output logic [lse_pkg::M_USER_W-1:0]  m_tuser,   // [0] has_value, [2:1] status
    output logic                          m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEEK,
        S_SWAP_A,
        S_SWAP_B,
        S_SWAP_C,
        S_DUMP
    } state_t;

    state_t                         state_reg, state_next;
    logic [lse_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [lse_pkg::ADDR_W-1:0]     idx_reg, idx_next;
    logic [lse_pkg::DATA_W-1:0]     top_reg, top_next;

    logic [lse_pkg::DATA_W-1:0]     mem [lse_pkg::STACK_DEPTH];
    logic [lse_pkg::DATA_W-1:0]     rd_data_reg;
    logic                           mem_we;
    logic [lse_pkg::ADDR_W-1:0]     mem_wa, mem_ra;
    logic [lse_pkg::DATA_W-1:0]     mem_wd;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [lse_pkg::DATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [lse_pkg::M_USER_W-1:0]   m_tuser_reg, m_tuser_next;
    logic                           m_tlast_reg, m_tlast_next;

    logic                           out_free, out_load;
    logic [lse_pkg::DATA_W-1:0]     out_value;
    logic                           out_has, out_last;
    lse_pkg::status_t               out_status;

    logic [lse_pkg::CNT_W-1:0]      cnt_m1, cnt_m2;
    logic [lse_pkg::ADDR_W-1:0]     top_addr, sec_addr;
    logic                           is_empty, is_full, is_short;

    assign cnt_m1   = count_reg - lse_pkg::CNT_W'(1);
    assign cnt_m2   = count_reg - lse_pkg::CNT_W'(2);
    assign top_addr = cnt_m1[lse_pkg::ADDR_W-1:0];
    assign sec_addr = cnt_m2[lse_pkg::ADDR_W-1:0];
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == lse_pkg::CNT_W'(lse_pkg::STACK_DEPTH));
    assign is_short = (count_reg < lse_pkg::CNT_W'(2));
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        top_next   = top_reg;
        mem_we     = 1'b0;
        mem_wa     = top_addr;
        mem_wd     = top_reg;
        mem_ra     = top_addr;
        out_load   = 1'b0;
        out_value  = '0;
        out_has    = 1'b0;
        out_status = lse_pkg::ST_OK;
        out_last   = 1'b1;
        q_pop      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                // a request is taken only when its first result has a free slot
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_req.op)
                        lse_pkg::OP_PUSH: begin
                            out_load = 1'b1;
                            if (is_full) begin
                                out_status = lse_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_wa     = count_reg[lse_pkg::ADDR_W-1:0];
                                mem_wd     = q_req.value;
                                count_next = count_reg + lse_pkg::CNT_W'(1);
                            end
                        end
                        lse_pkg::OP_POP: begin
                            out_load = 1'b1;
                            if (is_empty) begin
                                out_status = lse_pkg::ST_EMPTY;
                            end else begin
                                count_next = cnt_m1;
                            end
                        end
                        lse_pkg::OP_SWAP: begin
                            if (is_short) begin
                                out_load   = 1'b1;
                                out_status = lse_pkg::ST_EMPTY;
                            end else begin
                                state_next = S_SWAP_A;
                            end
                        end
                        lse_pkg::OP_PEEK: begin
                            if (is_empty) begin
                                out_load   = 1'b1;
                                out_status = lse_pkg::ST_EMPTY;
                            end else begin
                                state_next = S_PEEK;
                            end
                        end
                        lse_pkg::OP_DUMP: begin
                            if (is_empty) begin
                                out_load = 1'b1;
                            end else begin
                                idx_next   = top_addr;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PEEK: begin
                out_load   = 1'b1;
                out_value  = rd_data_reg;
                out_has    = 1'b1;
                state_next = S_IDLE;
            end
            S_SWAP_A: begin
                top_next   = rd_data_reg;
                mem_ra     = sec_addr;
                state_next = S_SWAP_B;
            end
            S_SWAP_B: begin
                mem_we     = 1'b1;
                mem_wa     = top_addr;
                mem_wd     = rd_data_reg;
                state_next = S_SWAP_C;
            end
            S_SWAP_C: begin
                mem_we     = 1'b1;
                mem_wa     = sec_addr;
                mem_wd     = top_reg;
                out_load   = 1'b1;
                state_next = S_IDLE;
            end
            S_DUMP: begin
                // hold the read address while stalled so the data stays valid
                mem_ra = idx_reg;
                if (out_free) begin
                    out_load  = 1'b1;
                    out_value = rd_data_reg;
                    out_has   = 1'b1;
                    out_last  = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                        mem_ra   = idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = out_value;
            m_tuser_next  = {out_status, out_has};
            m_tlast_next  = out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg     <= idx_next;
        top_reg     <= top_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/lifo_stack_engine.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_engine
// Bounded LIFO stack of signed 32-bit values: push, pop, swap, peek, dump.
//
// channel  dir  tdata                tuser                            tlast
// s_       in   [31:0] push_value    [2:0] action                     -
// m_       out  [31:0] value         [0] has_value, [2:1] status      last
//
// Push and pop finish in S_IDLE, peek goes on to S_PEEK, swap to S_SWAP_A,
// S_SWAP_B and S_SWAP_C, dump to S_DUMP; a refused peek or swap finishes in
// S_IDLE: the entry memory has one registered read port and one write port.
// Reset clears the entry count and control; the entry memory is not cleared.
// A two-entry request queue lets the input keep accepting while results stall.
// Unknown actions are consumed without any result.
// ----------------------------------------------------------------------------
module lifo_stack_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lse_pkg::S_USER_W-1:0]  s_tuser,   // [2:0] action
    input  logic [lse_pkg::DATA_W-1:0]    s_tdata,   // [31:0] push_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lse_pkg::DATA_W-1:0]    m_tdata,   // [31:0] value
    output logic [lse_pkg::M_USER_W-1:0]  m_tuser,   // [0] has_value, [2:1] status
    output logic                          m_tlast
);

    logic           q_full, q_push, q_pop, q_valid;
    lse_pkg::req_t  push_req, pop_req;

    lse_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_req    (push_req)
    );

    lse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_req  (push_req),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_req   (pop_req)
    );

    lse_exec u_exec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_req    (pop_req),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
